FILE: design/circular_list_append_delete_assert.svh
// Assertion macros shared by the circular list design files.
`ifndef CIRCULAR_LIST_APPEND_DELETE_ASSERT_SVH
`define CIRCULAR_LIST_APPEND_DELETE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/clad_pkg.sv
// Shared types and constants of the circular list block.
`timescale 1ns / 1ps
package clad_pkg;

	localparam int VALUE_W  = 32;
	localparam int SIZE_W   = 5;
	localparam int STATUS_W = 2;
	// magnitude bits of a signed position
	localparam int POS_BITS = VALUE_W - 1;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_e_t;

endpackage

FILE: design/clad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module clad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/clad_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module clad_rem #(
	parameter int DIV_W = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [clad_pkg::POS_BITS-1:0] dividend,
	input  logic [DIV_W-1:0]              divisor,
	output logic                          done,
	output logic [DIV_W-1:0]              rem
);
	import clad_pkg::*;

	`include "circular_list_append_delete_assert.svh"

	localparam int STEP_W = $clog2(POS_BITS);

	logic                running_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [POS_BITS-1:0] shift_q;
	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W:0]      trial;
	logic                take;

	// shift in next dividend bit, subtract when it fits
	assign trial = {rem_q, shift_q[POS_BITS-1]};
	assign take  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			step_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				step_q    <= STEP_W'(POS_BITS - 1);
			end else if (running_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (running_q) begin
			shift_q <= {shift_q[POS_BITS-2:0], 1'b0};
			rem_q   <= take ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	`ASSERT_IMPLIES(a_rem_below_div, clk, arst_n, done_q, rem_q < divisor)

endmodule

FILE: design/circular_list_append_delete.sv
// Top level of the circular list: sequencer, element RAM and remainder unit.
`timescale 1ns / 1ps
// Circular list of up to CAPACITY signed 32-bit words, head at slot 0.
// Command channel: a word (op, value, position) is taken at a clock edge
// with start high and busy low. busy stays high while a command is worked.
// Result channel: done is high for exactly one cycle with status,
// removed_value and list_size; the receiver must take it then.
// An append or a refused command gives done in the cycle after its start edge.
// A delete at position 1 or less removes the head; a larger position runs
// a bit-serial remainder, 31 steps, to get (position-1) mod size. The tail
// behind the removed slot then moves up one place, each slot read and then
// written, through the single RAM port pair.
// A new command may be taken at the edge that ends the done cycle.
// Reset clears the element count and the sequencer; the RAM itself is
// not cleared, as slots at or above the count are never read.
module circular_list_append_delete #(
	parameter int CAPACITY = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic                                     op,
	input  logic signed [clad_pkg::VALUE_W-1:0]      value,
	input  logic signed [clad_pkg::VALUE_W-1:0]      position,
	output logic                                     done,
	output logic        [clad_pkg::STATUS_W-1:0]     status,
	output logic signed [clad_pkg::VALUE_W-1:0]      removed_value,
	output logic        [clad_pkg::SIZE_W-1:0]       list_size
);
	import clad_pkg::*;

	`include "circular_list_append_delete_assert.svh"

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,      // remainder unit working
		S_RD_RM,    // address the slot to be removed
		S_WAIT_RM,  // removed word arrives
		S_SH_RD,    // read the slot behind
		S_SH_WR     // write it one place up
	} state_e_t;

	state_e_t         state_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    idx_q;
	logic             done_q;
	status_e_t        status_q;
	logic [VALUE_W-1:0] removed_q;

	logic                accept;
	logic                is_full;
	logic                pos_far;
	logic                rem_start;
	logic                rem_done;
	logic [CW-1:0]       rem_val;
	logic [POS_BITS-1:0] dividend;
	logic [CW-1:0]       idx_plus1;
	logic [CW-1:0]       idx_plus2;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	assign busy    = state_q != S_IDLE;
	assign accept  = start && !busy;
	assign is_full = count_q >= CW'(CAPACITY);

	// position 2 or more needs the modulo; anything else deletes the head
	assign pos_far   = !position[POS_BITS] && (position[POS_BITS-1:0] > POS_BITS'(1));
	assign dividend  = position[POS_BITS-1:0] - POS_BITS'(1);
	assign rem_start = accept && (op == OP_DELETE) && (count_q != '0) && pos_far;

	assign idx_plus1 = CW'(idx_q) + CW'(1);
	assign idx_plus2 = CW'(idx_q) + CW'(2);

	// append writes at the tail straight from the command word
	assign ram_we    = (accept && (op == OP_APPEND) && !is_full) || (state_q == S_SH_WR);
	assign ram_waddr = (state_q == S_SH_WR) ? idx_q : count_q[AW-1:0];
	assign ram_wdata = (state_q == S_SH_WR) ? ram_rdata : VALUE_W'(value);
	assign ram_raddr = (state_q == S_SH_RD) ? idx_q + AW'(1) : idx_q;

	clad_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	clad_rem #(
		.DIV_W(CW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (dividend),
		.divisor  (count_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			removed_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_APPEND) begin
							done_q    <= 1'b1;
							removed_q <= '0;
							if (is_full) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_OK;
								count_q  <= count_q + CW'(1);
							end
						end else if (count_q == '0) begin
							done_q    <= 1'b1;
							removed_q <= '0;
							status_q  <= ST_EMPTY;
						end else if (pos_far) begin
							state_q <= S_MOD;
						end else begin
							idx_q   <= '0;
							state_q <= S_RD_RM;
						end
					end
				end
				S_MOD: begin
					if (rem_done) begin
						idx_q   <= rem_val[AW-1:0];
						state_q <= S_RD_RM;
					end
				end
				S_RD_RM: begin
					state_q <= S_WAIT_RM;
				end
				S_WAIT_RM: begin
					removed_q <= ram_rdata;
					if (idx_plus1 < count_q) begin
						state_q <= S_SH_RD;
					end else begin
						count_q  <= count_q - CW'(1);
						status_q <= ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					idx_q <= idx_q + AW'(1);
					if (idx_plus2 < count_q) begin
						state_q <= S_SH_RD;
					end else begin
						count_q  <= count_q - CW'(1);
						status_q <= ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign list_size     = SIZE_W'(count_q);

	`ASSERT_IMPLIES(a_done_not_busy, clk, arst_n, done_q, !busy)
	`ASSERT_IMPLIES(a_count_cap, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`ASSERT_IMPLIES(a_refused_no_word, clk, arst_n, done_q && (status_q != ST_OK), removed_q == '0)
	`ASSERT_NEXT(a_accept_moves, clk, arst_n, accept, busy || done_q)

endmodule
